// ===== src/ctsc_pkg.sv =====
`timescale 1ns / 1ps

package ctsc_pkg;

  localparam int SampleWidth    = 16;
  localparam int CountWidth     = 8;
  localparam int FracExtra      = 8;
  localparam int LevelWidth     = SampleWidth + FracExtra;
  localparam int PoleWidth      = 16;
  localparam int PoleFrac       = 16;
  localparam int BitTimeWidth   = 8;
  localparam int SquelchWidth   = 15;
  localparam int ThresholdWidth = 16;
  localparam int CfgIndexWidth  = 3;
  localparam int CfgDataWidth   = 16;
  localparam int SumWidth       = LevelWidth + 3;

  localparam int InDataWidth  = ((3 * SampleWidth + 7) / 8) * 8;
  localparam int OutUsedWidth = 2 * SampleWidth + 5;
  localparam int OutDataWidth = ((OutUsedWidth + 7) / 8) * 8;

  typedef logic signed [SampleWidth-1:0] sample_t;
  typedef logic signed [LevelWidth-1:0]  level_t;
  typedef logic signed [1:0]             symbol_t;

  localparam symbol_t SymHigh = 2'sb01;
  localparam symbol_t SymIdle = 2'sb00;
  localparam symbol_t SymLow  = 2'sb11;

  // transmit bias -1.0 +/- 0.7, drive rails -5.0 and 0.0, all Q3.12
  localparam sample_t TxHighLevel = sample_t'(-1229);
  localparam sample_t TxLowLevel  = sample_t'(-6963);
  localparam sample_t DriveLow    = sample_t'(-20480);
  localparam sample_t DriveHigh   = sample_t'(0);

  typedef enum logic [CfgIndexWidth-1:0] {
    RegBitTime      = 3'd0,
    RegRxPole       = 3'd1,
    RegCdPole       = 3'd2,
    RegSquelch      = 3'd3,
    RegCollThresh   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    sample_t drive0;
    sample_t drive1;
    symbol_t rx_sym;
  } line_out_t;

endpackage

// ===== src/ctsc_pole_filter.sv =====
`timescale 1ns / 1ps

module ctsc_pole_filter (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  ctsc_pkg::sample_t                 sample,
  input  logic [ctsc_pkg::PoleWidth-1:0]    pole,
  output ctsc_pkg::level_t                  level_next
);
  import ctsc_pkg::*;

  localparam int DiffWidth = LevelWidth + 1;
  localparam int ProdWidth = DiffWidth + PoleWidth + 1;

  level_t                       level;
  level_t                       target;
  logic signed [DiffWidth-1:0]  diff;
  logic signed [PoleWidth:0]    pole_s;
  logic signed [ProdWidth-1:0]  prod;
  logic signed [ProdWidth-1:0]  rounded;

  assign target  = {sample, {FracExtra{1'b0}}};
  assign diff    = {target[LevelWidth-1], target} - {level[LevelWidth-1], level};
  assign pole_s  = {1'b0, pole};
  assign prod    = diff * pole_s;
  assign rounded = prod + (ProdWidth'(1) <<< (PoleFrac - 1));

  // step lies between zero and diff, so the sum wraps back into range
  assign level_next = level + rounded[PoleFrac +: LevelWidth];

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
    end else if (en) begin
      level <= level_next;
    end
  end

endmodule

// ===== src/ctsc_line_path.sv =====
`timescale 1ns / 1ps

module ctsc_line_path (
  input  ctsc_pkg::sample_t                 side0,
  input  ctsc_pkg::sample_t                 side1,
  input  ctsc_pkg::sample_t                 tx,
  input  ctsc_pkg::level_t                  dc0,
  input  ctsc_pkg::level_t                  dc1,
  input  logic [ctsc_pkg::SquelchWidth-1:0] squelch,
  output ctsc_pkg::line_out_t               line
);
  import ctsc_pkg::*;

  logic signed [SumWidth-1:0]    a_s, b_s, t_s, dc0_s, dc1_s;
  logic signed [SumWidth-1:0]    z, sq_hi, sq_lo;
  logic signed [SumWidth-1:0]    t_w, tsq_hi, tsq_lo;
  sample_t                       tx_level;
  symbol_t                       rx_sym;
  logic signed [SampleWidth:0]   d0, d1;

  function automatic sample_t clamp(input logic signed [SampleWidth:0] v);
    sample_t r;
    if (v < (SampleWidth+1)'(DriveLow)) begin
      r = DriveLow;
    end else if (v > (SampleWidth+1)'(DriveHigh)) begin
      r = DriveHigh;
    end else begin
      r = v[SampleWidth-1:0];
    end
    return r;
  endfunction

  assign a_s   = SumWidth'(level_t'({side0, {FracExtra{1'b0}}}));
  assign b_s   = SumWidth'(level_t'({side1, {FracExtra{1'b0}}}));
  assign t_s   = SumWidth'(level_t'({tx, {FracExtra{1'b0}}}));
  assign dc0_s = SumWidth'(dc0);
  assign dc1_s = SumWidth'(dc1);
  assign z     = t_s + (a_s - dc0_s) + (b_s - dc1_s);

  assign sq_hi = $signed({{(SumWidth-SquelchWidth-FracExtra){1'b0}}, squelch,
                          {FracExtra{1'b0}}});
  assign sq_lo = -sq_hi;

  assign t_w    = SumWidth'(tx);
  assign tsq_hi = $signed({{(SumWidth-SquelchWidth){1'b0}}, squelch});
  assign tsq_lo = -tsq_hi;

  always_comb begin
    if (z > sq_hi) begin
      rx_sym = SymHigh;
    end else if (z < sq_lo) begin
      rx_sym = SymLow;
    end else begin
      rx_sym = SymIdle;
    end

    if (t_w > tsq_hi) begin
      tx_level = TxHighLevel;
    end else if (t_w < tsq_lo) begin
      tx_level = TxLowLevel;
    end else begin
      tx_level = '0;
    end
  end

  assign d0 = (SampleWidth+1)'(side1) + (SampleWidth+1)'(tx_level);
  assign d1 = (SampleWidth+1)'(side0) + (SampleWidth+1)'(tx_level);
  assign line = {clamp(d0), clamp(d1), rx_sym};

endmodule

// ===== src/ctsc_tone_gen.sv =====
`timescale 1ns / 1ps

module ctsc_tone_gen (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              coll,
  input  logic [ctsc_pkg::BitTimeWidth-1:0] bit_time,
  output ctsc_pkg::symbol_t                 tone
);
  import ctsc_pkg::*;

  localparam int CmpWidth = (CountWidth > BitTimeWidth) ? CountWidth + 1 : BitTimeWidth + 1;
  localparam logic [CmpWidth-1:0] CountMax = CmpWidth'({CountWidth{1'b1}});

  logic [CountWidth-1:0] tone_count;
  logic [CountWidth-1:0] tone_count_next;
  logic [CountWidth-1:0] cur;
  logic [CmpWidth-1:0]   load_w;
  logic [CountWidth-1:0] load;
  logic [CmpWidth-1:0]   half;
  logic                  active;

  assign load_w = (bit_time == '0) ? CmpWidth'(1) : CmpWidth'(bit_time);
  assign load   = (load_w > CountMax) ? CountMax[CountWidth-1:0] : load_w[CountWidth-1:0];
  assign half   = CmpWidth'(bit_time >> 1);
  assign active = coll || (tone_count != '0);
  assign cur    = (tone_count == '0) ? load : tone_count;

  always_comb begin
    if (!active) begin
      tone            = SymIdle;
      tone_count_next = tone_count;
    end else begin
      tone            = (CmpWidth'(cur) > half) ? SymHigh : SymLow;
      tone_count_next = cur - CountWidth'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tone_count <= '0;
    end else if (en) begin
      tone_count <= tone_count_next;
    end
  end

endmodule

// ===== src/coax_transceiver_squelch_collision_unit.sv =====
`timescale 1ns / 1ps

// Coax transceiver with squelch and collision tone. Takes one item per clock
// while the output is not stalled and returns one result per item: a sample
// goes into an input register, the filters, squelch, clamps and tone counter
// work on it in one pass, and the result lands in an output register. The
// four one-pole filter states and the tone count update as each item leaves
// the input register, so the clock rate is bounded by that filter feedback
// loop (one 25x17 multiply and add). Write configuration only while idle.
module coax_transceiver_squelch_collision_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // line_side0, line_side1, transmit_sample
  input  logic [ctsc_pkg::InDataWidth-1:0]      s_tdata,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // drive_side0, drive_side1, receive_symbol, tone_symbol, collision_seen
  output logic [ctsc_pkg::OutDataWidth-1:0]     m_tdata,
  input  logic                                  cfg_write,
  input  logic [ctsc_pkg::CfgIndexWidth-1:0]    cfg_index,
  input  logic [ctsc_pkg::CfgDataWidth-1:0]     cfg_data
);
  import ctsc_pkg::*;

  logic [BitTimeWidth-1:0]   bit_time;
  logic [PoleWidth-1:0]      rx_pole;
  logic [PoleWidth-1:0]      cd_pole;
  logic [SquelchWidth-1:0]   squelch_level;
  logic signed [ThresholdWidth-1:0] coll_thresh;

  logic      in_valid;
  sample_t   in_side0, in_side1, in_tx;
  logic      adv;

  level_t    dc0_next, dc1_next, avg0_next, avg1_next;
  level_t    thresh_lvl;
  line_out_t line;
  logic      coll;
  symbol_t   tone;

  logic      out_valid;
  line_out_t out_line;
  symbol_t   out_tone;
  logic      out_coll;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_time      <= BitTimeWidth'(8);
      rx_pole       <= PoleWidth'(2731);
      cd_pole       <= PoleWidth'(1024);
      squelch_level <= SquelchWidth'(717);
      coll_thresh   <= ThresholdWidth'(-6144);
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        RegBitTime:    bit_time      <= cfg_data[BitTimeWidth-1:0];
        RegRxPole:     rx_pole       <= cfg_data[PoleWidth-1:0];
        RegCdPole:     cd_pole       <= cfg_data[PoleWidth-1:0];
        RegSquelch:    squelch_level <= cfg_data[SquelchWidth-1:0];
        RegCollThresh: coll_thresh   <= $signed(cfg_data[ThresholdWidth-1:0]);
        default: ;
      endcase
    end
  end

  assign adv      = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || adv;
  assign m_tvalid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_side0 <= s_tdata[0 +: SampleWidth];
      in_side1 <= s_tdata[SampleWidth +: SampleWidth];
      in_tx    <= s_tdata[2*SampleWidth +: SampleWidth];
    end
  end

  ctsc_pole_filter u_dc0 (
    .clk(clk), .rst(rst), .en(adv), .sample(in_side0), .pole(rx_pole),
    .level_next(dc0_next)
  );

  ctsc_pole_filter u_dc1 (
    .clk(clk), .rst(rst), .en(adv), .sample(in_side1), .pole(rx_pole),
    .level_next(dc1_next)
  );

  ctsc_line_path u_line (
    .side0(in_side0), .side1(in_side1), .tx(in_tx),
    .dc0(dc0_next), .dc1(dc1_next), .squelch(squelch_level),
    .line(line)
  );

  ctsc_pole_filter u_avg0 (
    .clk(clk), .rst(rst), .en(adv), .sample(line.drive0), .pole(cd_pole),
    .level_next(avg0_next)
  );

  ctsc_pole_filter u_avg1 (
    .clk(clk), .rst(rst), .en(adv), .sample(line.drive1), .pole(cd_pole),
    .level_next(avg1_next)
  );

  assign thresh_lvl = {coll_thresh, {FracExtra{1'b0}}};
  assign coll = (avg0_next < thresh_lvl) || (avg1_next < thresh_lvl);

  ctsc_tone_gen u_tone (
    .clk(clk), .rst(rst), .en(adv), .coll(coll), .bit_time(bit_time),
    .tone(tone)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= adv || (out_valid && !m_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_line <= line;
      out_tone <= tone;
      out_coll <= coll;
    end
  end

  assign m_tdata = {{(OutDataWidth-OutUsedWidth){1'b0}}, out_coll, out_tone,
                    out_line.rx_sym, out_line.drive1, out_line.drive0};

  a_coll_has_tone: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_coll) |-> (out_tone != SymIdle))
    else $error("collision result without tone");

  a_drive_in_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_line.drive0 <= DriveHigh && out_line.drive0 >= DriveLow &&
                   out_line.drive1 <= DriveHigh && out_line.drive1 >= DriveLow))
    else $error("drive outside rails");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && out_valid && !m_tready))
    else $error("input stalled with room downstream");

  a_item_moves: assert property (@(posedge clk) disable iff (rst)
    adv |=> out_valid)
    else $error("item lost between stages");

endmodule

// ===== bench/ctsc_line_checker.sv =====
`timescale 1ns / 1ps

module ctsc_line_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  input  logic                               s_tready,
  // line_side0, line_side1, transmit_sample
  input  logic [ctsc_pkg::InDataWidth-1:0]   s_tdata,
  input  logic                               m_tvalid,
  input  logic                               m_tready,
  // drive_side0, drive_side1, receive_symbol, tone_symbol, collision_seen
  input  logic [ctsc_pkg::OutDataWidth-1:0]  m_tdata,
  input  logic                               cfg_write,
  input  logic [ctsc_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [ctsc_pkg::CfgDataWidth-1:0]  cfg_data,
  output int                                 mismatches,
  output int                                 results_checked,
  output int                                 outstanding
);
  import ctsc_pkg::*;

  typedef struct {
    sample_t drive0;
    sample_t drive1;
    symbol_t rx_sym;
    symbol_t tone_sym;
    logic    coll;
  } line_result_t;

  line_result_t line_out_due[$];

  logic [BitTimeWidth-1:0]          bit_time;
  logic [PoleWidth-1:0]             rx_pole;
  logic [PoleWidth-1:0]             cd_pole;
  logic [SquelchWidth-1:0]          squelch;
  logic signed [ThresholdWidth-1:0] coll_thresh;

  // Q3.20 filter states
  longint dc_level0, dc_level1, coll_avg0, coll_avg1;
  int     tone_left;

  initial begin
    mismatches      = 0;
    results_checked = 0;
    outstanding     = 0;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
    mismatches++;
  endtask

  // round half up: floor((diff * pole + 32768) / 65536)
  function automatic longint one_pole(input longint level, input longint x, input longint pole);
    longint diff;
    diff = x * 256 - level;
    return level + ((diff * pole + 64'sd32768) >>> PoleFrac);
  endfunction

  function automatic longint clamp_drive(input longint v);
    if (v < longint'(DriveLow)) return longint'(DriveLow);
    if (v > longint'(DriveHigh)) return longint'(DriveHigh);
    return v;
  endfunction

  function automatic line_result_t compute_line_out(input sample_t a, input sample_t b,
                                                    input sample_t t);
    line_result_t r;
    longint sum, sq, bias, d0, d1;
    logic coll;
    sq = longint'(squelch);
    dc_level0 = one_pole(dc_level0, longint'(a), longint'(rx_pole));
    dc_level1 = one_pole(dc_level1, longint'(b), longint'(rx_pole));
    sum = longint'(t) * 256 + (longint'(a) * 256 - dc_level0)
        + (longint'(b) * 256 - dc_level1);
    if (sum > sq * 256) r.rx_sym = SymHigh;
    else if (sum < -sq * 256) r.rx_sym = SymLow;
    else r.rx_sym = SymIdle;

    if (longint'(t) > sq) bias = longint'(TxHighLevel);
    else if (longint'(t) < -sq) bias = longint'(TxLowLevel);
    else bias = 0;

    d0 = clamp_drive(longint'(b) + bias);
    d1 = clamp_drive(longint'(a) + bias);
    r.drive0 = sample_t'(d0);
    r.drive1 = sample_t'(d1);

    coll_avg0 = one_pole(coll_avg0, d0, longint'(cd_pole));
    coll_avg1 = one_pole(coll_avg1, d1, longint'(cd_pole));
    coll = (coll_avg0 < longint'(coll_thresh) * 256) || (coll_avg1 < longint'(coll_thresh) * 256);
    r.coll = coll;

    // tone runs to the end once started; half point follows the current bit time
    if (coll || tone_left != 0) begin
      if (tone_left == 0) tone_left = (bit_time == 0) ? 1 : int'(bit_time);
      r.tone_sym = (tone_left > (int'(bit_time) >> 1)) ? SymHigh : SymLow;
      tone_left--;
    end else begin
      r.tone_sym = SymIdle;
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    line_result_t want;
    sample_t a, b, t;
    if (rst) begin
      bit_time    = 8'd8;
      rx_pole     = 16'd2731;
      cd_pole     = 16'd1024;
      squelch     = 15'd717;
      coll_thresh = -16'sd6144;
      dc_level0   = 0;
      dc_level1   = 0;
      coll_avg0   = 0;
      coll_avg1   = 0;
      tone_left   = 0;
      line_out_due.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_reg_t'(cfg_index))
          RegBitTime:    bit_time    = cfg_data[BitTimeWidth-1:0];
          RegRxPole:     rx_pole     = cfg_data[PoleWidth-1:0];
          RegCdPole:     cd_pole     = cfg_data[PoleWidth-1:0];
          RegSquelch:    squelch     = cfg_data[SquelchWidth-1:0];
          RegCollThresh: coll_thresh = cfg_data[ThresholdWidth-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        a = s_tdata[SampleWidth-1:0];
        b = s_tdata[2*SampleWidth-1:SampleWidth];
        t = s_tdata[3*SampleWidth-1:2*SampleWidth];
        line_out_due.push_back(compute_line_out(a, b, t));
      end
      if (m_tvalid && m_tready) begin
        if (line_out_due.size() == 0) begin
          report_mismatch("result with none awaited",
                          longint'($signed(m_tdata[SampleWidth-1:0])), 0);
        end else begin
          want = line_out_due.pop_front();
          if (m_tdata[SampleWidth-1:0] !== want.drive0)
            report_mismatch("drive_side0", longint'($signed(m_tdata[SampleWidth-1:0])),
                            longint'(want.drive0));
          if (m_tdata[2*SampleWidth-1:SampleWidth] !== want.drive1)
            report_mismatch("drive_side1",
                            longint'($signed(m_tdata[2*SampleWidth-1:SampleWidth])),
                            longint'(want.drive1));
          if (m_tdata[2*SampleWidth+1:2*SampleWidth] !== want.rx_sym)
            report_mismatch("receive_symbol",
                            longint'($signed(m_tdata[2*SampleWidth+1:2*SampleWidth])),
                            longint'(want.rx_sym));
          if (m_tdata[2*SampleWidth+3:2*SampleWidth+2] !== want.tone_sym)
            report_mismatch("tone_symbol",
                            longint'($signed(m_tdata[2*SampleWidth+3:2*SampleWidth+2])),
                            longint'(want.tone_sym));
          if (m_tdata[2*SampleWidth+4] !== want.coll)
            report_mismatch("collision_seen", longint'(m_tdata[2*SampleWidth+4]),
                            longint'(want.coll));
        end
        results_checked <= results_checked + 1;
      end
    end
    outstanding = line_out_due.size();
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import ctsc_pkg::*;

  typedef enum {BurstIdle, BurstTalk, BurstClash, BurstWild} burst_kind_t;

  logic                     clk;
  logic                     rst;
  logic                     s_tvalid;
  logic                     s_tready;
  logic [InDataWidth-1:0]   s_tdata;
  logic                     m_tvalid;
  logic                     m_tready;
  logic [OutDataWidth-1:0]  m_tdata;
  logic                     cfg_write;
  logic [CfgIndexWidth-1:0] cfg_index;
  logic [CfgDataWidth-1:0]  cfg_data;

  int mismatches, results_checked, outstanding;
  int items_sent;
  int cur_bit_time;
  bit hold_sink;
  bit steady;

  coax_transceiver_squelch_collision_unit uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ctsc_line_checker line_check (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .results_checked (results_checked),
    .outstanding     (outstanding)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic sample_t near(input int centre, input int spread);
    return sample_t'(centre + int'($urandom_range(0, 2 * spread)) - spread);
  endfunction

  // sink side; a hold request stalls it for a long stretch
  initial begin : sink
    int stall_left;
    stall_left = 0;
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_sink) begin
        stall_left = 96;
        hold_sink  = 1'b0;
      end else if (stall_left == 0 && !steady && $urandom_range(0, 99) < 15) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic send_sample(input sample_t a, input sample_t b, input sample_t t);
    s_tdata  <= {t, b, a};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    if (!steady && $urandom_range(0, 99) < 20) begin
      s_tvalid <= 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (results_checked < items_sent) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_reg(input cfg_reg_t idx, input int value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CfgDataWidth'(value);
    @(posedge clk);
  endtask

  task automatic apply_setting(input int bt, input int rxp, input int cdp, input int sq,
                               input int th);
    set_reg(RegBitTime, bt);
    set_reg(RegRxPole, rxp);
    set_reg(RegCdPole, cdp);
    set_reg(RegSquelch, sq);
    set_reg(RegCollThresh, th);
    cfg_write <= 1'b0;
    cur_bit_time = bt;
  endtask

  task automatic run_burst(input burst_kind_t kind);
    int len, half;
    bit high;
    sample_t a, b, t;
    len  = $urandom_range(4, 40);
    half = (cur_bit_time < 2) ? 1 : cur_bit_time / 2;
    high = 1'b0;
    for (int k = 0; k < len; k++) begin
      if (k % half == 0) high = $urandom_range(0, 1);
      case (kind)
        BurstIdle: begin
          a = near(0, 200);
          b = near(0, 200);
          t = near(0, 200);
        end
        BurstTalk: begin
          a = near(-600, 400);
          b = near(-600, 400);
          t = high ? near(8000, 1500) : near(-8000, 1500);
        end
        BurstClash: begin
          a = near(-9000, 6000);
          b = near(-9000, 6000);
          t = high ? near(8000, 1500) : near(-8000, 1500);
        end
        default: begin
          a = sample_t'($urandom);
          b = sample_t'($urandom);
          t = sample_t'($urandom);
        end
      endcase
      send_sample(a, b, t);
    end
  endtask

  initial begin : stimulus
    int quota, pick;
    burst_kind_t kind;
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    cfg_write    = 1'b0;
    cfg_index    = RegBitTime;
    cfg_data     = '0;
    items_sent   = 0;
    cur_bit_time = 8;
    hold_sink    = 1'b0;
    steady       = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // field extremes and squelch edges under reset settings
    send_sample(0, 0, 0);
    send_sample(32767, 32767, 32767);
    send_sample(-32768, -32768, -32768);
    send_sample(32767, -32768, 0);
    send_sample(-32768, 32767, -1);
    send_sample(0, 0, 717);
    send_sample(0, 0, 718);
    send_sample(0, 0, -717);
    send_sample(0, 0, -718);
    send_sample(-20480, -20481, 0);
    send_sample(0, 0, -1);
    send_sample(1, 1, 0);

    // zero bit time loads a count of one
    settle();
    set_reg(RegCdPole, 65535);
    set_reg(RegBitTime, 0);
    cfg_write <= 1'b0;
    cur_bit_time = 0;
    send_sample(-20000, -20000, -9000);
    send_sample(-20000, -20000, -9000);
    send_sample(0, 0, 0);
    send_sample(0, 0, 0);

    // tone started at one bit time carries on after the bit time changes
    settle();
    set_reg(RegBitTime, 8);
    cfg_write <= 1'b0;
    send_sample(-20000, -20000, -9000);
    send_sample(-20000, -20000, -9000);
    settle();
    set_reg(RegBitTime, 2);
    cfg_write <= 1'b0;
    cur_bit_time = 2;
    repeat (4) send_sample(0, 0, 0);

    for (int p = 0; p < 8; p++) begin
      settle();
      case (p)
        0: apply_setting(2, 65535, 0, 0, 0);
        1: apply_setting(255, 0, 65535, 32767, -32768);
        7: apply_setting(8, 2731, 1024, 717, -6144);
        default: apply_setting($urandom_range(2, 24), $urandom_range(256, 16384),
                               $urandom_range(512, 8192), $urandom_range(200, 6000),
                               -int'($urandom_range(2000, 14000)));
      endcase
      steady = (p == 3 || p == 6);
      if (p == 3) hold_sink = 1'b1;
      quota = items_sent + 55;
      while (items_sent < quota) begin
        pick = $urandom_range(0, 99);
        if (pick < 35) kind = BurstTalk;
        else if (pick < 65) kind = BurstClash;
        else if (pick < 80) kind = BurstIdle;
        else kind = BurstWild;
        run_burst(kind);
      end
    end

    settle();
    repeat (12) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/ctsc_pkg.sv
src/ctsc_pole_filter.sv
src/ctsc_line_path.sv
src/ctsc_tone_gen.sv
src/coax_transceiver_squelch_collision_unit.sv
bench/ctsc_line_checker.sv
bench/tb_top.sv
